// ----- rtl/htbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htbp_pkg
// Shared types, constants and the hex digit classifier for the hex text to
// bitset parser.
// ----------------------------------------------------------------------------
package htbp_pkg;

    localparam int CH_W    = 8;
    localparam int COUNT_W = 7;
    localparam int SET_W   = 64;

    // Header/body separator character
    localparam logic [CH_W-1:0] CH_SEP = 8'h3A;

    // Parser phase codes
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_ERROR  = 2'd2;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] val;
    } t_hex;

    // Classify one character as a hex digit and give its value
    function automatic t_hex hex_decode(input logic [CH_W-1:0] c);
        t_hex h;
        logic [CH_W-1:0] d;
        h = '0;
        d = '0;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
            h.is_hex = 1'b1;
            h.val = d[3:0];
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
            h.is_hex = 1'b1;
            h.val = d[3:0];
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
            h.is_hex = 1'b1;
            h.val = d[3:0];
        end
        return h;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/hex_text_to_bitset_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Output: a result appears on the output register in the cycle after the
//   character marked last is accepted.
// Throughput: one character per cycle; the output register decouples the
//   sides, so input stalls only while a result waits and is not taken.
// Reset (synchronous, active low): parser returns to the header phase with
//   cleared count, overflow flag and set, and the output register empties.
// ----------------------------------------------------------------------------
// hex_text_to_bitset_parser
// Parses "count:bits" text one character per cycle (stalled while a result
// waits untaken) into a process count and a set vector masked below the count.
// ----------------------------------------------------------------------------
module hex_text_to_bitset_parser
    import htbp_pkg::*;
#(
    parameter int MAX_PROCS = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // character channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [CH_W-1:0]    i_ch,
    input  wire logic               i_last,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_ok,
    output logic [COUNT_W-1:0]      o_proc_count,
    output logic [SET_W-1:0]        o_members
);

    localparam int NEXT_W = COUNT_W + 4;

    // parser state
    logic [1:0]         r_phase,    n_phase;
    logic [COUNT_W-1:0] r_count,    n_count;
    logic               r_ovf,      n_ovf;
    logic [SET_W-1:0]   r_bits,     n_bits;

    // result register
    logic               r_out_valid;
    logic               r_ok;
    logic [COUNT_W-1:0] r_proc_count;
    logic [SET_W-1:0]   r_members;

    logic               in_acc;
    t_hex               hx;
    logic [NEXT_W-1:0]  count_next;
    logic               good;
    logic [SET_W-1:0]   mask;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;
    assign hx         = hex_decode(i_ch);
    assign count_next = {r_count, 4'h0} + NEXT_W'(hx.val);

    // next state for one character
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_bits  = r_bits;
        case (r_phase)
            PH_HEADER: begin
                if (i_ch == CH_SEP) begin
                    n_phase = PH_BODY;
                end else if (hx.is_hex) begin
                    if (r_ovf || (count_next > NEXT_W'(MAX_PROCS))) begin
                        n_ovf = 1'b1;
                    end
                    n_count = count_next[COUNT_W-1:0];
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_BODY: begin
                if (hx.is_hex) begin
                    n_bits = {r_bits[SET_W-5:0], hx.val};
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase
    end

    // final check and mask of positions at or above the count
    assign good = (n_phase == PH_BODY) && (n_count != '0) && !n_ovf;

    always_comb begin
        for (int i = 0; i < SET_W; i++) begin
            mask[i] = (COUNT_W'(i) < n_count);
        end
    end

    // parser state registers; cleared after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_bits  <= '0;
        end else if (in_acc) begin
            if (i_last) begin
                r_phase <= PH_HEADER;
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_bits  <= '0;
            end else begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_ovf   <= n_ovf;
                r_bits  <= n_bits;
            end
        end
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (in_acc && i_last) begin
            r_ok         <= good;
            r_proc_count <= good ? n_count : '0;
            r_members    <= good ? (n_bits & mask) : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_ok         = r_ok;
    assign o_proc_count = r_proc_count;
    assign o_members    = r_members;

    // checks
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_ok) |-> (r_proc_count == '0 && r_members == '0))
        else $error("error result carries nonzero payload");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ok) |->
            (r_proc_count != '0 && r_proc_count <= COUNT_W'(MAX_PROCS)))
        else $error("accepted result has count out of range");

    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last) |=> r_out_valid)
        else $error("no result after last character");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last) |=>
            (r_phase == PH_HEADER && r_count == '0 && !r_ovf && r_bits == '0))
        else $error("parser state not cleared after last character");

endmodule
`default_nettype wire

// ----- tb/hex_text_to_bitset_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_text_to_bitset_parser_tb
// Feeds "count:bits" texts one character per request to the parser: a short
// set of hand-written well-formed texts and header and body fault cases, then
// random texts, mostly well formed, some corrupted, some pure noise. A local
// parser model predicts each result; a checker process compares every result
// field by field. Sender and receiver idle at random in two of three phases.
// ----------------------------------------------------------------------------
module hex_text_to_bitset_parser_tb
    import htbp_pkg::*;
();

    localparam int MAX_PROCS   = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_PAD   = 10;

    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] proc_count;
        logic [SET_W-1:0]   members;
    } t_parse_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [CH_W-1:0]    i_ch = '0;
    logic               i_last = 1'b0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_ok;
    logic [COUNT_W-1:0] o_proc_count;
    logic [SET_W-1:0]   o_members;

    // parser model state
    logic [1:0]         parse_phase = PH_HEADER;
    logic [COUNT_W-1:0] hdr_count = '0;
    logic               hdr_overflow = 1'b0;
    logic [SET_W-1:0]   set_bits = '0;

    t_parse_result      expected_results[$];
    t_parse_result      want;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 error_count = 0;
    int                 cycle_count = 0;

    hex_text_to_bitset_parser #(
        .MAX_PROCS    (MAX_PROCS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_ch         (i_ch),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_ok         (o_ok),
        .o_proc_count (o_proc_count),
        .o_members    (o_members)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Digit value 0..15, or 16 for a non-hex character
    function automatic logic [4:0] digit_value(input logic [CH_W-1:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
        if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
        return 5'd16;
    endfunction

    // Hex character for a digit, random letter case
    function automatic logic [CH_W-1:0] hex_char(input int v);
        if (v < 10) return 8'("0" + v);
        if ($urandom_range(1) == 0) return 8'("a" + v - 10);
        return 8'("A" + v - 10);
    endfunction

    // Advance the parser model by one accepted character
    task automatic parse_char(input logic [CH_W-1:0] c, input logic is_last);
        logic [4:0]       v;
        int               nxt;
        logic [SET_W-1:0] mask;
        t_parse_result    res;
        v = digit_value(c);
        case (parse_phase)
            PH_HEADER: begin
                if (c == CH_SEP) begin
                    parse_phase = PH_BODY;
                end else if (v < 16) begin
                    nxt = int'(hdr_count) * 16 + int'(v);
                    if (hdr_overflow || nxt > MAX_PROCS) hdr_overflow = 1'b1;
                    hdr_count = nxt[COUNT_W-1:0];
                end else begin
                    parse_phase = PH_ERROR;
                end
            end
            PH_BODY: begin
                if (v < 16) set_bits = {set_bits[SET_W-5:0], v[3:0]};
                else parse_phase = PH_ERROR;
            end
            default: parse_phase = PH_ERROR;
        endcase
        if (is_last) begin
            res = '0;
            if (parse_phase == PH_BODY && hdr_count != 0 && !hdr_overflow) begin
                mask = (hdr_count >= SET_W) ? '1 : ((SET_W'(1) << hdr_count) - 1);
                res.ok = 1'b1;
                res.proc_count = hdr_count;
                res.members = set_bits & mask;
            end
            expected_results.push_back(res);
            parse_phase = PH_HEADER;
            hdr_count = '0;
            hdr_overflow = 1'b0;
            set_bits = '0;
        end
    endtask

    // Result checker and receiver stalls
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result ok=%0b count=%0d members=%h",
                         $time, o_ok, o_proc_count, o_members);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_ok !== want.ok) begin
                    $display("%0t: ok expected %0b actual %0b", $time, want.ok, o_ok);
                    error_count++;
                end
                if (o_proc_count !== want.proc_count) begin
                    $display("%0t: proc_count expected %0d actual %0d",
                             $time, want.proc_count, o_proc_count);
                    error_count++;
                end
                if (o_members !== want.members) begin
                    $display("%0t: members expected %h actual %h",
                             $time, want.members, o_members);
                    error_count++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Send one character request, with random lead-in gaps
    task automatic send_char(input logic [CH_W-1:0] c, input logic is_last);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_ch       <= c;
        i_last     <= is_last;
        do @(posedge i_clk); while (!o_in_ready);
        parse_char(c, is_last);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    // Hold the sender until every expected result has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // Texts that parse: minimal and full counts, mask, empty body, mixed case
    task automatic test_wellformed_texts();
        send_text("1:1");
        send_text("40:f");
        send_text("3:Ab");
        send_text("5:");
    endtask

    // Header faults: overflow, zero count, empty header, missing colon, NUL
    task automatic test_header_faults();
        send_text("41:");
        send_text("0:");
        send_text(":");
        send_text("A");
        send_char("3", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(CH_SEP, 1'b1);
    endtask

    // Body faults: non-hex digit, second colon
    task automatic test_body_faults();
        send_text("2:g");
        send_text("2::");
    endtask

    // Build one random text: mostly well formed, some corrupted, some noise
    task automatic send_random_text(output int n_chars);
        logic [CH_W-1:0] txt[$];
        int              r;
        int              cnt;
        int              ndig;
        int              lead;
        int              nbody;
        r = $urandom_range(99);
        if (r < 12) begin
            repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(255)));
            if ($urandom_range(3) == 0) txt.push_back(CH_SEP);
        end else begin
            r = $urandom_range(99);
            if (r < 4) cnt = 0;
            else if (r < 14) cnt = MAX_PROCS;
            else if (r < 24) cnt = $urandom_range(MAX_PROCS + 1, 4095);
            else cnt = $urandom_range(1, MAX_PROCS - 1);
            ndig = 1;
            while ((cnt >> (4 * ndig)) != 0) ndig++;
            lead = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
            repeat (lead) txt.push_back(hex_char(0));
            for (int i = ndig - 1; i >= 0; i--) txt.push_back(hex_char((cnt >> (4 * i)) & 15));
            txt.push_back(CH_SEP);
            // mostly short bodies, a few that shift past the top position
            nbody = ($urandom_range(9) == 0) ? $urandom_range(17, 24) : $urandom_range(0, 16);
            repeat (nbody) txt.push_back(hex_char($urandom_range(15)));
            r = $urandom_range(99);
            if (r < 10) txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
            else if (r < 14) txt = txt[0:lead + ndig - 1];
        end
        for (int i = 0; i < txt.size(); i++) send_char(txt[i], i == txt.size() - 1);
        n_chars = txt.size();
    endtask

    task automatic test_random_texts(input int min_chars, input int min_texts);
        int sent;
        int texts;
        int n;
        sent = 0;
        texts = 0;
        while (sent < min_chars || texts < min_texts) begin
            send_random_text(n);
            sent += n;
            texts++;
        end
    endtask

    // Test sequence
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 11;
        recv_idle_pct = 55;
        test_wellformed_texts();
        test_header_faults();
        test_body_faults();
        test_random_texts(120, 8);
        wait_drained();

        send_idle_pct = 55;
        recv_idle_pct = 11;
        test_random_texts(120, 8);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_texts(120, 8);
        wait_drained();

        repeat (DRAIN_PAD) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- hex_text_to_bitset_parser.f -----
rtl/htbp_pkg.sv
rtl/hex_text_to_bitset_parser.sv
tb/hex_text_to_bitset_parser_tb.sv
